[rtl/core/wps_pkg.sv]
// Package: shared constants, types and controller state encoding for the price statistics unit.
`default_nettype none
package wps_pkg;
  localparam int WindowMax = 64;
  localparam int PriceWidth = 32;
  localparam int PtrWidth = $clog2(WindowMax);
  localparam int CntWidth = $clog2(WindowMax + 1);
  localparam int SumWidth = PriceWidth + PtrWidth;
  localparam int SqWidth = 2 * PriceWidth + PtrWidth;
  localparam int VarWidth = 2 * PriceWidth;
  localparam int RootWidth = PriceWidth;
  localparam int QuoWidth = SumWidth;
  localparam int MulWidth = 17;
  localparam logic [MulWidth-1:0] MulMax = MulWidth'(65536);
  localparam logic [6:0] LenReset = 7'd16;
  localparam logic [MulWidth-1:0] MulReset = MulWidth'(7710);

  // configuration register indexes
  localparam logic [0:0] CfgWindowLength = 1'b0;
  localparam logic [0:0] CfgEmaMultiplier = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM_RD,
    ST_SUM,
    ST_DIV_MEAN,
    ST_SQ_RD,
    ST_SQ,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_DIV_VAR,
    ST_ROOT,
    ST_OUT
  } wps_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic ring_write;
    logic ring_read;
    logic clear_acc;
    logic sum_acc;
    logic div_start_mean;
    logic div_start_var;
    logic first_elem;
    logic sq_mul;
    logic sq_acc;
    logic root_start;
    logic load_out;
    logic zero_out;
    logic step_idx;
  } wps_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_elem;
    logic full;
    logic div_done;
    logic root_done;
  } wps_status_t;
endpackage
`default_nettype wire

[rtl/core/windowed_price_statistics_unit.sv]
// Top level of the windowed price statistics unit.
// One sample at a time: each transfer writes the ring and then walks the window
// twice (once for the sum, once for squares and EMA), with a bit-serial divide
// after each walk (mean, then variance) and a bit-serial square root. With a
// short window the walks are skipped and the result carries zeros. The ring
// memory's single port sets the walk rate.
`default_nettype none
module windowed_price_statistics_unit import wps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PriceWidth-1:0] price,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                moving_average,
  output logic [31:0]                std_deviation,
  output logic [31:0]                exp_average,
  output logic                       window_full,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [MulWidth-1:0]   cfg_data
);
  wps_cmd_t    cmd;
  wps_status_t status;

  assign cfg_ready = 1'b1;

  wps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  wps_dp u_dp (
    .clk(clk), .rst(rst), .price(price), .cfg_we(cfg_valid && cfg_ready),
    .cfg_idx(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .status(status),
    .moving_average(moving_average), .std_deviation(std_deviation),
    .exp_average(exp_average), .window_full(window_full)
  );

  // no new sample is taken while a result is pending
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while result pending");

  // a short window result carries zeros
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !window_full) |-> (moving_average == 32'd0 && std_deviation == 32'd0))
    else $error("nonzero statistics without full window");
endmodule
`default_nettype wire

[rtl/core/wps_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module wps_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/core/wps_ctrl.sv]
// Controller state machine sequencing the window passes, divides and root.
`default_nettype none
module wps_ctrl import wps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire wps_status_t status,
  output wps_cmd_t         cmd
);
  wps_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_WRITE;
      ST_WRITE:    state_next = status.full ? ST_SUM_RD : ST_OUT;
      ST_SUM_RD:   state_next = ST_SUM;
      ST_SUM:      state_next = status.last_elem ? ST_DIV_MEAN : ST_SUM_RD;
      ST_DIV_MEAN: if (status.div_done) state_next = ST_SQ_RD;
      ST_SQ_RD:    state_next = ST_SQ;
      ST_SQ:       state_next = ST_SQ_MUL;
      ST_SQ_MUL:   state_next = ST_SQ_ACC;
      ST_SQ_ACC:   state_next = status.last_elem ? ST_DIV_VAR : ST_SQ_RD;
      ST_DIV_VAR:  if (status.div_done) state_next = ST_ROOT;
      ST_ROOT:     if (status.root_done) state_next = ST_OUT;
      ST_OUT:      if (!out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
    case (state)
      ST_IDLE:  if (in_valid) cmd.ring_write = 1'b1;
      ST_WRITE: begin
        cmd.clear_acc = 1'b1;
        cmd.ring_read = 1'b1;
        cmd.load_out = 1'b1;
        cmd.zero_out = 1'b1;
      end
      ST_SUM_RD: cmd.ring_read = 1'b1;
      ST_SUM: begin
        cmd.sum_acc = 1'b1;
        cmd.step_idx = 1'b1;
        cmd.div_start_mean = status.last_elem;
      end
      ST_DIV_MEAN: cmd.ring_read = 1'b1;
      // read data for the address set in ST_SQ_RD is valid here
      ST_SQ: cmd.ring_read = 1'b1;
      ST_SQ_MUL: cmd.sq_mul = 1'b1;
      ST_SQ_ACC: begin
        cmd.sq_acc = 1'b1;
        cmd.step_idx = 1'b1;
        cmd.div_start_var = status.last_elem;
      end
      ST_DIV_VAR: cmd.root_start = status.div_done;
      ST_ROOT: cmd.load_out = status.root_done;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/wps_dp.sv]
// Datapath: sample ring, accumulators, serial divider, serial square root and EMA.
`default_nettype none
module wps_dp import wps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [PriceWidth-1:0] price,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_idx,
  input  wire logic [MulWidth-1:0]   cfg_data,
  input  wire wps_cmd_t              cmd,
  output wps_status_t                status,
  output logic [31:0]                moving_average,
  output logic [31:0]                std_deviation,
  output logic [31:0]                exp_average,
  output logic                       window_full
);
  logic [6:0]            window_length;
  logic [MulWidth-1:0]   ema_multiplier;
  logic [PtrWidth-1:0]   write_pointer;
  logic [CntWidth-1:0]   samples_seen;
  logic [CntWidth-1:0]   n_eff;
  logic [MulWidth-1:0]   m_eff;
  logic [PtrWidth-1:0]   idx;
  logic [CntWidth-1:0]   count;
  logic [PtrWidth-1:0]   ram_addr;
  logic [PriceWidth-1:0] ram_rdata;
  logic [SumWidth-1:0]   sum;
  logic [PriceWidth-1:0] mean;
  logic [SqWidth-1:0]    sq;
  logic [VarWidth-1:0]   prod;
  logic [PriceWidth-1:0] ema;
  logic                  first;
  logic [PriceWidth-1:0] x;
  logic [PriceWidth-1:0] dev;

  // effective window length and multiplier
  always_comb begin
    if (window_length == 7'd0) n_eff = CntWidth'(1);
    else if (32'(window_length) > WindowMax) n_eff = CntWidth'(WindowMax);
    else n_eff = CntWidth'(window_length);
    m_eff = (ema_multiplier > MulMax) ? MulMax : ema_multiplier;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LenReset;
      ema_multiplier <= MulReset;
    end else if (cfg_we) begin
      if (cfg_idx == CfgWindowLength) window_length <= cfg_data[6:0];
      else ema_multiplier <= cfg_data;
    end
  end

  assign ram_addr = cmd.ring_write ? write_pointer : idx;

  wps_ram #(.Width(PriceWidth), .Depth(WindowMax)) u_ring (
    .clk(clk), .we(cmd.ring_write), .addr(ram_addr), .wdata(price), .rdata(ram_rdata)
  );

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      samples_seen <= '0;
    end else if (cmd.ring_write) begin
      write_pointer <= write_pointer + 1'b1;
      if (32'(samples_seen) < WindowMax) samples_seen <= samples_seen + 1'b1;
    end
  end

  assign status.full = (samples_seen >= n_eff);
  assign status.last_elem = (count == n_eff - 1'b1);

  // window walk index; sample read data arrives in the cycle after the address
  always_ff @(posedge clk) begin
    if (cmd.clear_acc || cmd.div_start_mean) begin
      idx <= write_pointer - PtrWidth'(n_eff);
      count <= '0;
    end else if (cmd.step_idx) begin
      idx <= idx + 1'b1;
      count <= count + 1'b1;
    end
  end

  // hold sample from read
  always_ff @(posedge clk) begin
    if (cmd.ring_read) x <= ram_rdata;
  end

  assign dev = (x >= mean) ? x - mean : mean - x;

  // divider shared by mean and variance: restoring, one bit per cycle
  logic [VarWidth+PtrWidth-1:0] dnum;
  logic [CntWidth:0]            drem;
  logic [CntWidth:0]            dtrial;
  logic [$clog2(SqWidth+1)-1:0] dcnt;
  logic                         dbusy;
  logic                         dvar;
  logic [VarWidth-1:0]          var_q;

  assign dtrial = {drem[CntWidth-1:0], dnum[SqWidth-1]};

  // last term of each walk is folded in as the divide starts
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start_mean || cmd.div_start_var) begin
      dbusy <= 1'b1;
      dvar <= cmd.div_start_var;
      drem <= '0;
      dcnt <= '0;
      dnum <= cmd.div_start_var ? SqWidth'(sq + SqWidth'(prod))
                                : SqWidth'(sum + SumWidth'(ram_rdata));
    end else if (dbusy) begin
      if (dtrial >= {1'b0, n_eff}) begin
        drem <= dtrial - {1'b0, n_eff};
        dnum <= {dnum[SqWidth-2:0], 1'b1};
      end else begin
        drem <= dtrial;
        dnum <= {dnum[SqWidth-2:0], 1'b0};
      end
      dcnt <= dcnt + 1'b1;
      if (32'(dcnt) == SqWidth - 1) dbusy <= 1'b0;
    end
  end

  logic ddone;
  assign ddone = dbusy && (32'(dcnt) == SqWidth - 1);
  assign status.div_done = !dbusy;

  // capture quotient results
  always_ff @(posedge clk) begin
    if (ddone) begin
      if (dvar) var_q <= VarWidth'({dnum[SqWidth-2:0], dtrial >= {1'b0, n_eff}});
      else mean <= PriceWidth'({dnum[SqWidth-2:0], dtrial >= {1'b0, n_eff}});
    end
  end

  // sum, squared deviation and EMA accumulation
  logic signed [PriceWidth+1:0]          ediff;
  logic signed [PriceWidth+MulWidth+2:0] eprod;
  logic [PriceWidth-1:0]                 x_d;
  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      sum <= '0;
      sq <= '0;
      first <= 1'b1;
    end else begin
      if (cmd.sum_acc && !status.last_elem) sum <= sum + SumWidth'(ram_rdata);
      if (cmd.sq_mul) begin
        prod <= VarWidth'(dev) * VarWidth'(dev);
        x_d <= x;
        ediff <= $signed({2'b00, x}) - $signed({2'b00, ema});
      end
      if (cmd.sq_acc) begin
        sq <= sq + SqWidth'(prod);
        first <= 1'b0;
        if (first) ema <= x_d;
        else ema <= PriceWidth'(ema + PriceWidth'(eprod >>> 16));
      end
    end
  end
  assign eprod = ediff * $signed({2'b00, m_eff});

  // square root: one result bit per cycle
  logic [RootWidth-1:0]          root;
  logic [$clog2(RootWidth)-1:0]  rbit;
  logic                          rbusy;
  logic [RootWidth-1:0]          cand;
  assign cand = root | (RootWidth'(1) << rbit);
  assign status.root_done = !rbusy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rbusy <= 1'b0;
    end else if (cmd.root_start) begin
      rbusy <= 1'b1;
      root <= '0;
      rbit <= $clog2(RootWidth)'(RootWidth - 1);
    end else if (rbusy) begin
      if (VarWidth'(cand) * VarWidth'(cand) <= var_q) root <= cand;
      if (rbit == '0) rbusy <= 1'b0;
      rbit <= rbit - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.zero_out) begin
        moving_average <= '0;
        std_deviation <= '0;
        exp_average <= '0;
        window_full <= 1'b0;
      end else begin
        moving_average <= 32'(mean);
        std_deviation <= 32'(root);
        exp_average <= 32'(ema);
        window_full <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire
